// ===== rtl/tfd_pkg.sv =====
package tfd_pkg;

   localparam int PALETTE_ENTRIES = 65536;
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
   // address sums are formed at this width, then wrapped to PAL_AW bits
   localparam int SUM_W = 18;

   localparam logic [2:0] FMT_DISABLED = 3'd0;
   localparam logic [2:0] FMT_A3I5     = 3'd1;
   localparam logic [2:0] FMT_2BPP     = 3'd2;
   localparam logic [2:0] FMT_4BPP     = 3'd3;
   localparam logic [2:0] FMT_8BPP     = 3'd4;
   localparam logic [2:0] FMT_4X4      = 3'd5;
   localparam logic [2:0] FMT_A5I3     = 3'd6;
   localparam logic [2:0] FMT_DIRECT   = 3'd7;

   localparam logic KIND_PAL_WRITE = 1'b0;

   localparam logic [1:0] REG_FORMAT     = 2'd0;
   localparam logic [1:0] REG_PAL_BASE   = 2'd1;
   localparam logic [1:0] REG_ZERO_CLEAR = 2'd2;

   localparam logic [1:0] MODE_3COLOR = 2'd0;
   localparam logic [1:0] MODE_AVG    = 2'd1;
   localparam logic [1:0] MODE_4COLOR = 2'd2;
   localparam logic [1:0] MODE_MIX    = 2'd3;

   localparam logic [1:0] SRC_RAM    = 2'd0;
   localparam logic [1:0] SRC_DIRECT = 2'd1;
   localparam logic [1:0] SRC_ZERO   = 2'd2;
   localparam logic [1:0] SRC_BLOCK  = 2'd3;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] BLOCK_READS   = 5'd4;
   localparam logic [STEP_W-1:0] LAST_STEP_4X4 = 5'd19;

   typedef struct packed {
      logic [2:0]  texture_format;
      logic [12:0] pal_base;
      logic        color_zero_clear;
   } tfd_cfg_type;

   typedef struct packed {
      logic        out_en;
      logic [1:0]  src;
      logic [7:0]  alpha;
      logic [14:0] rgb;
      logic        load;
      logic [1:0]  slot;
      logic [1:0]  mode;
      logic [3:0]  pos;
      logic        last;
   } tfd_op_type;

   typedef struct packed {
      logic              wr_en;
      logic [PAL_AW-1:0] wr_addr;
      logic [14:0]       wr_data;
      logic              rd_en;
      logic [PAL_AW-1:0] rd_addr;
   } tfd_mem_req_type;

   function automatic logic [7:0] widen5(input logic [4:0] c);
      return {c, c[4:2]};
   endfunction

   function automatic logic [31:0] to_argb(input logic [14:0] rgb, input logic [7:0] alpha);
      return {alpha, widen5(rgb[4:0]), widen5(rgb[9:5]), widen5(rgb[14:10])};
   endfunction

   // (5a + 3b) >> 3
   function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b);
      logic [10:0] s;
      s = {1'b0, a, 2'b00} + {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, b};
      return s[10:3];
   endfunction

   function automatic logic [7:0] avg_chan(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic logic [31:0] blend_argb(input logic [31:0] c0, input logic [31:0] c1);
      return {8'hFF, blend_chan(c0[23:16], c1[23:16]), blend_chan(c0[15:8], c1[15:8]),
              blend_chan(c0[7:0], c1[7:0])};
   endfunction

   function automatic logic [31:0] avg_argb(input logic [31:0] c0, input logic [31:0] c1);
      return {8'hFF, avg_chan(c0[23:16], c1[23:16]), avg_chan(c0[15:8], c1[15:8]),
              avg_chan(c0[7:0], c1[7:0])};
   endfunction

endpackage

// ===== rtl/tfd_pal_mem.sv =====
module tfd_pal_mem (
   input  logic                     clock,
   input  tfd_pkg::tfd_mem_req_type mem_req,
   output logic [14:0]              rd_data
);
   import tfd_pkg::*;

   logic [14:0] ram_ff [PALETTE_ENTRIES];
   logic [14:0] rd_data_ff;

   // read data holds while no read is issued, so a stalled pipe keeps it
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ram_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= ram_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tfd_seq.sv =====
module tfd_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  tfd_pkg::tfd_cfg_type     cfg,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [15:0]              req_palette_entry,
   input  logic [14:0]              req_palette_color,
   input  logic [31:0]              req_texel_word,
   input  logic [15:0]              req_block_info,
   input  logic                     advance,
   output tfd_pkg::tfd_mem_req_type mem_req,
   output tfd_pkg::tfd_op_type      op
);
   import tfd_pkg::*;

   logic              slot_valid_ff;
   logic              kind_ff;
   logic [PAL_AW-1:0] entry_ff;
   logic [14:0]       color_ff;
   logic [31:0]       word_ff;
   logic [15:0]       info_ff;
   logic [STEP_W-1:0] step_ff;

   logic              issue;
   logic              done;
   logic              accept;
   logic              need_rd;
   logic [STEP_W-1:0] last_step;
   logic [SUM_W-1:0]  rd_sum;
   logic [SUM_W-1:0]  base8;
   logic [SUM_W-1:0]  base4;
   logic [7:0]        byte_w;
   logic [1:0]        idx2;
   logic [3:0]        idx4;
   logic [3:0]        blk_j;
   logic [1:0]        blk_idx;

   assign issue     = slot_valid_ff && advance;
   assign done      = issue && (step_ff == last_step);
   assign req_ready = !slot_valid_ff || done;
   assign accept    = req_valid && req_ready;

   assign byte_w  = word_ff[7:0];
   assign base8   = SUM_W'({cfg.pal_base, 3'b000});
   assign base4   = SUM_W'({cfg.pal_base, 2'b00});
   assign idx2    = byte_w[{step_ff[1:0], 1'b0} +: 2];
   assign idx4    = step_ff[0] ? byte_w[7:4] : byte_w[3:0];
   assign blk_j   = 4'(step_ff - BLOCK_READS);
   assign blk_idx = word_ff[{blk_j, 1'b0} +: 2];

   always_comb begin
      op        = '0;
      need_rd   = 1'b0;
      rd_sum    = '0;
      last_step = '0;
      mem_req   = '0;
      if (kind_ff == KIND_PAL_WRITE) begin
         mem_req.wr_en   = issue;
         mem_req.wr_addr = entry_ff;
         mem_req.wr_data = color_ff;
      end else begin
         case (cfg.texture_format)
            FMT_A3I5: begin
               need_rd  = 1'b1;
               rd_sum   = base8 + SUM_W'(byte_w[4:0]);
               op.out_en = 1'b1;
               op.src   = SRC_RAM;
               op.alpha = {byte_w[7:5], byte_w[7:5], byte_w[7:6]};
               op.last  = 1'b1;
            end
            FMT_A5I3: begin
               need_rd  = 1'b1;
               rd_sum   = base8 + SUM_W'(byte_w[2:0]);
               op.out_en = 1'b1;
               op.src   = SRC_RAM;
               op.alpha = {byte_w[7:3], byte_w[7:5]};
               op.last  = 1'b1;
            end
            FMT_2BPP: begin
               last_step = 5'd3;
               need_rd   = 1'b1;
               rd_sum    = base4 + SUM_W'(idx2);
               op.out_en = 1'b1;
               op.src    = (cfg.color_zero_clear && idx2 == 2'd0) ? SRC_ZERO : SRC_RAM;
               op.alpha  = 8'hFF;
               op.pos    = {2'b00, step_ff[1:0]};
               op.last   = (step_ff[1:0] == 2'd3);
            end
            FMT_4BPP: begin
               last_step = 5'd1;
               need_rd   = 1'b1;
               rd_sum    = base8 + SUM_W'(idx4);
               op.out_en = 1'b1;
               op.src    = (cfg.color_zero_clear && idx4 == 4'd0) ? SRC_ZERO : SRC_RAM;
               op.alpha  = 8'hFF;
               op.pos    = {3'b000, step_ff[0]};
               op.last   = step_ff[0];
            end
            FMT_8BPP: begin
               need_rd   = 1'b1;
               rd_sum    = base8 + SUM_W'(byte_w);
               op.out_en = 1'b1;
               op.src    = (cfg.color_zero_clear && byte_w == 8'd0) ? SRC_ZERO : SRC_RAM;
               op.alpha  = 8'hFF;
               op.last   = 1'b1;
            end
            FMT_DIRECT: begin
               op.out_en = 1'b1;
               op.src    = SRC_DIRECT;
               op.rgb    = word_ff[14:0];
               op.alpha  = {8{word_ff[15]}};
               op.last   = 1'b1;
            end
            FMT_4X4: begin
               last_step = LAST_STEP_4X4;
               op.mode   = info_ff[15:14];
               if (step_ff < BLOCK_READS) begin
                  // fetch the four block palette entries into the unit
                  need_rd = 1'b1;
                  rd_sum  = base8 + SUM_W'({info_ff[13:0], 1'b0}) + SUM_W'(step_ff[1:0]);
                  op.load = 1'b1;
                  op.slot = step_ff[1:0];
               end else begin
                  op.out_en = 1'b1;
                  op.src    = SRC_BLOCK;
                  op.slot   = blk_idx;
                  op.pos    = blk_j;
                  op.last   = (blk_j == 4'd15);
               end
            end
            FMT_DISABLED: begin
               op = '0;
            end
            default: begin
               op = '0;
            end
         endcase
      end
      mem_req.rd_en   = issue && need_rd;
      mem_req.rd_addr = rd_sum[PAL_AW-1:0];
      if (!slot_valid_ff) begin
         op = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else if (accept) begin
         slot_valid_ff <= 1'b1;
         step_ff       <= '0;
      end else if (done) begin
         slot_valid_ff <= 1'b0;
         step_ff       <= '0;
      end else if (issue) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         entry_ff <= req_palette_entry[PAL_AW-1:0];
         color_ff <= req_palette_color;
         word_ff  <= req_texel_word;
         info_ff  <= req_block_info;
      end
   end

endmodule

// ===== rtl/tfd_texel_unit.sv =====
module tfd_texel_unit (
   input  logic                clock,
   input  logic                reset,
   input  tfd_pkg::tfd_op_type op,
   input  logic [14:0]         rd_data,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_texel_color,
   output logic [3:0]          rsp_texel_position,
   output logic                rsp_last_texel
);
   import tfd_pkg::*;

   tfd_op_type  op_ff;
   logic [31:0] pal_ff [4];
   logic        rsp_valid_ff;
   logic [31:0] color_ff;
   logic [3:0]  pos_ff;
   logic        last_ff;

   logic [31:0] ram_argb;
   logic [31:0] texel;
   logic [31:0] load_val;

   // whole pipe moves together; only a stalled output word holds it
   assign advance  = !rsp_valid_ff || rsp_ready;
   assign ram_argb = to_argb(rd_data, 8'hFF);

   always_comb begin
      case (op_ff.src)
         SRC_RAM:    texel = to_argb(rd_data, op_ff.alpha);
         SRC_DIRECT: texel = to_argb(op_ff.rgb, op_ff.alpha);
         SRC_ZERO:   texel = '0;
         SRC_BLOCK:  texel = pal_ff[op_ff.slot];
         default:    texel = '0;
      endcase
   end

   // slots 0 and 1 are loaded before 2 and 3, so blends see them registered
   always_comb begin
      load_val = ram_argb;
      if (op_ff.slot == 2'd2) begin
         case (op_ff.mode)
            MODE_3COLOR: load_val = ram_argb;
            MODE_AVG:    load_val = avg_argb(pal_ff[0], pal_ff[1]);
            MODE_4COLOR: load_val = ram_argb;
            MODE_MIX:    load_val = blend_argb(pal_ff[0], pal_ff[1]);
            default:     load_val = ram_argb;
         endcase
      end else if (op_ff.slot == 2'd3) begin
         case (op_ff.mode)
            MODE_3COLOR: load_val = '0;
            MODE_AVG:    load_val = '0;
            MODE_4COLOR: load_val = ram_argb;
            MODE_MIX:    load_val = blend_argb(pal_ff[1], pal_ff[0]);
            default:     load_val = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         op_ff        <= op;
         rsp_valid_ff <= op_ff.out_en;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && op_ff.out_en) begin
         color_ff <= texel;
         pos_ff   <= op_ff.pos;
         last_ff  <= op_ff.last;
      end
      if (advance && op_ff.load) begin
         pal_ff[op_ff.slot] <= load_val;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_texel_color    = color_ff;
   assign rsp_texel_position = pos_ff;
   assign rsp_last_texel     = last_ff;

endmodule

// ===== rtl/texture_texel_format_decoder.sv =====
// path: sequencer slot, then op and palette read data registers, then the texel word;
// a 4x4 block makes its four palette reads before its first texel
// throughput while the output is not stalled: one item per cycle for A3I5, A5I3, 8bpp,
// direct and palette writes; 4bpp makes 2 texels, 2bpp 4, a 4x4 block 4 palette reads
// then 16 texels before the next item; single palette read port, one texel word per cycle
// reset: clears the sequencer, the pipe and the config registers, not the palette RAM
module texture_texel_format_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_palette_entry,
   input  logic [14:0] req_palette_color,
   input  logic [31:0] req_texel_word,
   input  logic [15:0] req_block_info,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_texel_color,
   output logic [3:0]  rsp_texel_position,
   output logic        rsp_last_texel,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import tfd_pkg::*;

   tfd_cfg_type     cfg_ff;
   tfd_mem_req_type mem_req;
   tfd_op_type      op;
   logic [14:0]     rd_data;
   logic            advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FORMAT:     cfg_ff.texture_format   <= csr_wdata[2:0];
            REG_PAL_BASE:   cfg_ff.pal_base         <= csr_wdata;
            REG_ZERO_CLEAR: cfg_ff.color_zero_clear <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   tfd_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_palette_entry (req_palette_entry),
      .req_palette_color (req_palette_color),
      .req_texel_word    (req_texel_word),
      .req_block_info    (req_block_info),
      .advance           (advance),
      .mem_req           (mem_req),
      .op                (op)
   );

   tfd_pal_mem u_pal_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   tfd_texel_unit u_texel_unit (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .rd_data            (rd_data),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_texel_color    (rsp_texel_color),
      .rsp_texel_position (rsp_texel_position),
      .rsp_last_texel     (rsp_last_texel)
   );

endmodule
